/* design/cbp_pkg.sv */
package cbp_pkg;

    localparam int WORD_W = 64;
    localparam int NBITS_W = 7;
    localparam int ACC_W = WORD_W + 7;
    localparam int ACC_CNT_W = 7;
    localparam int LIMIT_W = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] MODE_UNSIGNED = 2'd0;
    localparam logic [1:0] MODE_SIGNED = 2'd1;
    localparam logic [1:0] MODE_SPARSE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PACK_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS_M1 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NZ_LIMIT = 2'd3;

    // One coefficient after classification: bits to append, LSB first.
    typedef struct packed {
        logic [WORD_W-1:0]  bits;
        logic [NBITS_W-1:0] nbits;
        logic               last;
    } entry_t;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } out_t;

endpackage

/* design/cbp_queue.sv */
module cbp_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] rdata,
    output logic              empty
);
    localparam int DEPTH = 2;

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              do_push;
    logic              do_pop;

    assign full = (count_reg == 2'(DEPTH));
    assign empty = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 2'(DEPTH))
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg == rd_ptr_reg) |-> (count_reg == 2'd0 || count_reg == 2'(DEPTH)))
        else $error("queue pointers disagree with count");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> !empty)
        else $error("queue lost a transaction");

endmodule

/* design/cbp_front.sv */
module cbp_front #(
    parameter int COEFFS_PER_POLY = 512,
    parameter int POSITION_BITS = 9,
    parameter int MAX_WIDTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [cbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cbp_pkg::WORD_W-1:0]      cfg_data,
    output logic                            cfg_ready,
    input  logic                            accept,
    input  logic [cbp_pkg::WORD_W-1:0]      coeff_word,
    input  logic                            last_coeff,
    output cbp_pkg::entry_t                 entry
);
    import cbp_pkg::*;

    localparam int IDX_W = (COEFFS_PER_POLY > 1) ? $clog2(COEFFS_PER_POLY) : 1;

    logic [1:0]         mode_reg;
    logic [NBITS_W-1:0] width_reg;
    logic [WORD_W-1:0]  mod_m1_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [LIMIT_W-1:0] nz_reg;
    logic [LIMIT_W-1:0] nz_next;

    logic [NBITS_W-1:0] w_eff;
    logic [WORD_W-1:0]  mask;
    logic [WORD_W-1:0]  biased;
    logic               sparse_hit;
    logic               sign_bit;
    logic [POSITION_BITS-1:0] pos;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_UNSIGNED;
            width_reg <= 7'd8;
            mod_m1_reg <= '0;
            limit_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PACK_MODE:   mode_reg <= cfg_data[1:0];
                REG_COEFF_WIDTH: width_reg <= cfg_data[NBITS_W-1:0];
                REG_MODULUS_M1:  mod_m1_reg <= cfg_data;
                REG_NZ_LIMIT:    limit_reg <= cfg_data[LIMIT_W-1:0];
                default:         mode_reg <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        w_eff = (width_reg > NBITS_W'(MAX_WIDTH)) ? NBITS_W'(MAX_WIDTH) : width_reg;
        mask = (w_eff >= NBITS_W'(WORD_W)) ? '1 : ((WORD_W'(1) << w_eff) - WORD_W'(1));
        biased = coeff_word;
        if (mode_reg == MODE_SIGNED && w_eff != '0)
        begin
            biased = coeff_word + (WORD_W'(1) << (w_eff - NBITS_W'(1)));
        end
        sparse_hit = (coeff_word != '0) && (nz_reg < limit_reg);
        sign_bit = (coeff_word == mod_m1_reg);
        pos = POSITION_BITS'(idx_reg);

        entry.last = last_coeff;
        if (mode_reg == MODE_SPARSE)
        begin
            // skipped entries carry no bits so the gearbox stays clean above its count
            entry.bits = sparse_hit ? WORD_W'({sign_bit, pos}) : '0;
            entry.nbits = sparse_hit ? NBITS_W'(POSITION_BITS + 1) : '0;
        end
        else
        begin
            entry.bits = biased & mask;
            entry.nbits = w_eff;
        end

        idx_next = (idx_reg == IDX_W'(COEFFS_PER_POLY - 1)) ? '0 : idx_reg + IDX_W'(1);
        nz_next = nz_reg;
        if (mode_reg == MODE_SPARSE && sparse_hit)
        begin
            nz_next = nz_reg + LIMIT_W'(1);
        end
        if (last_coeff)
        begin
            idx_next = '0;
            nz_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            nz_reg <= '0;
        end
        else if (accept)
        begin
            idx_reg <= idx_next;
            nz_reg <= nz_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_coeff) |=> (idx_reg == '0 && nz_reg == '0))
        else $error("counters not cleared after last coefficient");
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode_reg == MODE_SPARSE && nz_reg >= limit_reg) |-> entry.nbits == '0)
        else $error("sparse entry packed past the limit");
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode_reg != MODE_SPARSE) |-> ((entry.bits & ~mask) == '0))
        else $error("bits above the width reach the gearbox");

endmodule

/* design/cbp_gearbox.sv */
module cbp_gearbox (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_empty,
    input  cbp_pkg::entry_t in_entry,
    output logic            in_pop,
    input  logic            out_full,
    output logic            out_push,
    output cbp_pkg::out_t   out_item
);
    import cbp_pkg::*;

    // acc holds cnt valid bits, LSB first; bits above cnt are always zero.
    logic [ACC_W-1:0]     acc_reg;
    logic [ACC_W-1:0]     acc_next;
    logic [ACC_CNT_W-1:0] cnt_reg;
    logic [ACC_CNT_W-1:0] cnt_next;
    logic                 flush_reg;
    logic                 flush_next;

    logic                 emit_want;
    logic                 emit;
    logic [ACC_CNT_W-1:0] rem;
    logic                 load;
    logic [ACC_W-1:0]     acc_shift;

    always_comb
    begin
        emit_want = (cnt_reg >= ACC_CNT_W'(8)) || (flush_reg && cnt_reg != '0);
        emit = emit_want && !out_full;
        if (emit)
        begin
            rem = (cnt_reg >= ACC_CNT_W'(8)) ? cnt_reg - ACC_CNT_W'(8) : '0;
            acc_shift = acc_reg >> 8;
        end
        else
        begin
            rem = cnt_reg;
            acc_shift = acc_reg;
        end
        load = !in_empty && (rem < ACC_CNT_W'(8)) && (!flush_reg || rem == '0);

        if (load)
        begin
            acc_next = acc_shift | (ACC_W'(in_entry.bits) << rem[2:0]);
            cnt_next = rem + ACC_CNT_W'(in_entry.nbits);
            flush_next = in_entry.last;
        end
        else
        begin
            acc_next = acc_shift;
            cnt_next = rem;
            flush_next = flush_reg && (rem != '0);
        end

        in_pop = load;
        out_push = emit;
        out_item.data = acc_reg[7:0];
        out_item.last = flush_reg && (cnt_reg <= ACC_CNT_W'(8));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            flush_reg <= flush_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= ACC_CNT_W'(ACC_W))
        else $error("gearbox bit count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && cnt_reg < ACC_CNT_W'(8)) |-> flush_reg)
        else $error("partial byte sent outside a flush");
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && out_item.last && !load) |=> (cnt_reg == '0 && !flush_reg))
        else $error("state left over after final byte");

endmodule

/* design/coefficient_bit_packer.sv */
// A coefficient accepted on the input passes through the entry queue, the
// gearbox and the result queue before its first byte shows on the result side.
// Throughput: one coefficient per cycle while each adds at most 8 bits and
// results are popped; the gearbox sends one byte per cycle, so wider ones lag.
// Reset (rst_n low, asynchronous) empties both queues, clears pending bits and
// counters, and loads the registers with mode 0, width 8, zero, zero.
module coefficient_bit_packer #(
    parameter int COEFFS_PER_POLY = 512,
    parameter int POSITION_BITS = 9,
    parameter int MAX_WIDTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [cbp_pkg::WORD_W-1:0]    coeff_word,
    input  logic                          last_coeff,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    out_byte,
    output logic                          last_byte,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cbp_pkg::WORD_W-1:0]    cfg_data
);
    import cbp_pkg::*;

    logic   accept;
    entry_t fe_entry;
    entry_t q_entry;
    logic   q_empty;
    logic   q_pop;
    logic   o_full;
    logic   o_push;
    out_t   o_item;
    out_t   o_head;

    assign accept = push && !full;

    cbp_front #(
        .COEFFS_PER_POLY(COEFFS_PER_POLY),
        .POSITION_BITS(POSITION_BITS),
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .cfg_ready(cfg_ready),
        .accept(accept),
        .coeff_word(coeff_word),
        .last_coeff(last_coeff),
        .entry(fe_entry)
    );

    cbp_queue #(
        .DATA_W($bits(entry_t))
    ) u_entry_q (
        .clk(clk),
        .rst_n(rst_n),
        .push(accept),
        .wdata(fe_entry),
        .full(full),
        .pop(q_pop),
        .rdata(q_entry),
        .empty(q_empty)
    );

    cbp_gearbox u_gearbox (
        .clk(clk),
        .rst_n(rst_n),
        .in_empty(q_empty),
        .in_entry(q_entry),
        .in_pop(q_pop),
        .out_full(o_full),
        .out_push(o_push),
        .out_item(o_item)
    );

    cbp_queue #(
        .DATA_W($bits(out_t))
    ) u_out_q (
        .clk(clk),
        .rst_n(rst_n),
        .push(o_push),
        .wdata(o_item),
        .full(o_full),
        .pop(pop),
        .rdata(o_head),
        .empty(empty)
    );

    assign out_byte = o_head.data;
    assign last_byte = o_head.last;

endmodule

/* dv/coefficient_bit_packer_checker.sv */
`timescale 1ns / 1ps

module coefficient_bit_packer_checker #(
    parameter int COEFFS_PER_POLY = 512,
    parameter int POSITION_BITS = 9,
    parameter int MAX_WIDTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          full,
    input  logic [cbp_pkg::WORD_W-1:0]    coeff_word,
    input  logic                          last_coeff,
    input  logic                          empty,
    input  logic                          pop,
    input  logic [7:0]                    out_byte,
    input  logic                          last_byte,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [cbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cbp_pkg::WORD_W-1:0]    cfg_data,
    output int                            mismatch_count,
    output int                            results_due
);
    import cbp_pkg::*;

    logic [1:0]        mode_q;
    logic [6:0]        width_q;
    logic [WORD_W-1:0] minus_one_q;
    logic [9:0]        nz_limit_q;

    logic [7:0]        byte_acc;
    int                bit_count;
    int                coeff_pos;
    int                nz_count;

    out_t              byte_q[$];
    int                errors = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        errors++;
    endtask

    // LSB first into the byte accumulator; a full byte becomes an expected result
    task automatic append_bits(input logic [WORD_W-1:0] val, input int nbits);
        for (int i = 0; i < nbits; i++)
        begin
            byte_acc[bit_count] = val[i];
            bit_count++;
            if (bit_count == 8)
            begin
                byte_q.push_back('{last: 1'b0, data: byte_acc});
                byte_acc = '0;
                bit_count = 0;
            end
        end
    endtask

    task automatic pack_coeff(input logic [WORD_W-1:0] word, input logic last);
        int                       eff_width;
        int                       queued_at_start;
        logic [WORD_W-1:0]        biased;
        logic [POSITION_BITS-1:0] slot;
        logic [POSITION_BITS:0]   entry;
        out_t                     tail;

        queued_at_start = byte_q.size();
        eff_width = (width_q > MAX_WIDTH) ? MAX_WIDTH : int'(width_q);

        if (mode_q == MODE_SPARSE)
        begin
            if (word != '0 && nz_count < nz_limit_q)
            begin
                slot = coeff_pos[POSITION_BITS-1:0];
                entry = {word == minus_one_q, slot};
                append_bits(WORD_W'(entry), POSITION_BITS + 1);
                nz_count++;
            end
        end
        else if (eff_width > 0)
        begin
            // unused mode code falls through to plain unsigned packing
            biased = word;
            if (mode_q == MODE_SIGNED)
                biased = word + (64'd1 << (eff_width - 1));
            append_bits(biased, eff_width);
        end

        coeff_pos = (coeff_pos + 1) % COEFFS_PER_POLY;

        if (last)
        begin
            if (bit_count > 0)
                byte_q.push_back('{last: 1'b0, data: byte_acc});
            if (byte_q.size() > queued_at_start)
            begin
                tail = byte_q.pop_back();
                tail.last = 1'b1;
                byte_q.push_back(tail);
            end
            byte_acc = '0;
            bit_count = 0;
            coeff_pos = 0;
            nz_count = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;

        if (!rst_n)
        begin
            mode_q = MODE_UNSIGNED;
            width_q = 7'd8;
            minus_one_q = '0;
            nz_limit_q = '0;
            byte_acc = '0;
            bit_count = 0;
            coeff_pos = 0;
            nz_count = 0;
            byte_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PACK_MODE:   mode_q = cfg_data[1:0];
                    REG_COEFF_WIDTH: width_q = cfg_data[6:0];
                    REG_MODULUS_M1:  minus_one_q = cfg_data;
                    REG_NZ_LIMIT:    nz_limit_q = cfg_data[9:0];
                    default:         ;
                endcase
            end

            if (push && !full)
                pack_coeff(coeff_word, last_coeff);

            if (pop && !empty)
            begin
                if (byte_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected byte %02h last %0b",
                                              out_byte, last_byte));
                end
                else
                begin
                    want = byte_q.pop_front();
                    if (out_byte !== want.data)
                        report_mismatch($sformatf("out_byte got %02h, expected %02h",
                                                  out_byte, want.data));
                    if (last_byte !== want.last)
                        report_mismatch($sformatf("last_byte got %0b, expected %0b (byte %02h)",
                                                  last_byte, want.last, want.data));
                end
            end
        end

        results_due <= byte_q.size();
        mismatch_count <= errors;
    end

endmodule

/* dv/coefficient_bit_packer_tb.sv */
`timescale 1ns / 1ps

module coefficient_bit_packer_tb;
    import cbp_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [WORD_W-1:0]    coeff_word;
    logic                 last_coeff;
    logic                 empty;
    logic                 pop;
    logic [7:0]           out_byte;
    logic                 last_byte;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    int                   mismatch_count;
    int                   results_due;
    int                   idle_cycles = 0;
    logic                 hold_off_req;
    logic                 no_gaps;
    logic [1:0]           cur_mode;
    logic [WORD_W-1:0]    cur_minus_one;

    coefficient_bit_packer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .coeff_word (coeff_word),
        .last_coeff (last_coeff),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .last_byte  (last_byte),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    coefficient_bit_packer_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .coeff_word     (coeff_word),
        .last_coeff     (last_coeff),
        .empty          (empty),
        .pop            (pop),
        .out_byte       (out_byte),
        .last_byte      (last_byte),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [WORD_W-1:0] make_coeff();
        int r;
        r = $urandom_range(0, 9);
        if (cur_mode == MODE_SPARSE)
        begin
            if (r < 4)
                return '0;
            if (r < 6)
                return cur_minus_one;
        end
        else
        begin
            if (r < 2)
                return (r == 0) ? WORD_W'($urandom_range(0, 15)) : -WORD_W'($urandom_range(1, 16));
            if (r < 3)
                return '1;
        end
        return {$urandom, $urandom};
    endfunction

    // one input transaction; push stays high on return so back-to-back items need no gap
    task automatic send_coeff(input logic [WORD_W-1:0] word, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        coeff_word <= word;
        last_coeff <= last;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic send_poly(input int len);
        for (int i = 0; i < len; i++)
            send_coeff(make_coeff(), i == len - 1);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic configure(input logic [1:0] mode, input logic [6:0] width,
                             input logic [WORD_W-1:0] minus_one, input logic [9:0] limit);
        cfg_put(REG_PACK_MODE, WORD_W'(mode));
        cfg_put(REG_COEFF_WIDTH, WORD_W'(width));
        cfg_put(REG_MODULUS_M1, minus_one);
        cfg_put(REG_NZ_LIMIT, WORD_W'(limit));
        cfg_valid <= 1'b0;
        cur_mode = mode;
        cur_minus_one = minus_one;
    endtask

    // results_due is registered in the checker, so look only after push has dropped
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        bit hold_taken;
        hold_taken = 1'b0;
        pop <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            int gap;
            gap = pick_gap();
            if (hold_off_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                gap = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [6:0]        width;
        logic [9:0]        limit;
        logic [WORD_W-1:0] minus_one;
        int                sent;
        int                len;

        rst_n <= 1'b0;
        push <= 1'b0;
        coeff_word <= '0;
        last_coeff <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_PACK_MODE;
        cfg_data <= '0;
        hold_off_req <= 1'b0;
        no_gaps <= 1'b0;
        cur_mode = MODE_UNSIGNED;
        cur_minus_one = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: unsigned, 8 bits
        send_coeff('0, 1'b0);
        send_coeff(64'hA5, 1'b0);
        send_coeff('1, 1'b1);
        drain();

        // single bit, upper bits dropped, partial byte flushed
        configure(MODE_UNSIGNED, 7'd1, '0, '0);
        send_coeff(64'h1, 1'b0);
        send_coeff('0, 1'b0);
        send_coeff(64'h1, 1'b0);
        send_coeff('1, 1'b1);
        drain();

        // full width with bias carry out of the top bit
        configure(MODE_SIGNED, 7'd64, '0, '0);
        send_coeff('0, 1'b0);
        send_coeff(64'h8000_0000_0000_0000, 1'b0);
        send_coeff('1, 1'b1);
        drain();

        // unused mode code and width clamp
        configure(MODE_UNUSED, 7'd127, '1, 10'd1023);
        send_coeff(64'h0123_4567_89AB_CDEF, 1'b0);
        send_coeff('1, 1'b1);
        drain();

        // width zero: no bits, and a last with nothing pending gives no byte
        configure(MODE_SIGNED, 7'd0, '0, '0);
        send_coeff('1, 1'b0);
        send_coeff(64'h5, 1'b1);
        drain();

        // challenge entries, minus one sign, limit of three reached
        configure(MODE_SPARSE, 7'd8, '1, 10'd3);
        send_coeff('0, 1'b0);
        send_coeff('1, 1'b0);
        send_coeff(64'h5, 1'b0);
        send_coeff('0, 1'b0);
        send_coeff(64'h7, 1'b0);
        send_coeff('1, 1'b0);
        send_coeff('0, 1'b1);
        drain();

        // longer polynomial: positions climb, dense run at the end
        minus_one = {$urandom, $urandom};
        configure(MODE_SPARSE, 7'd8, minus_one, 10'd512);
        for (int i = 0; i < 64; i++)
        begin
            if (i >= 56 || $urandom_range(0, 7) == 0)
                send_coeff(($urandom_range(0, 2) == 0) ? minus_one : {$urandom, $urandom} | 64'h1,
                           i == 63);
            else
                send_coeff('0, i == 63);
        end
        drain();

        // receiver holds off while wide coefficients keep coming
        configure(MODE_UNSIGNED, 7'd64, '0, '0);
        hold_off_req <= 1'b1;
        send_poly(40);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case ($urandom_range(0, 7))
                0:       width = 7'd0;
                1:       width = 7'd1;
                2:       width = 7'd64;
                3:       width = 7'd127;
                4:       width = 7'd8;
                default: width = 7'($urandom_range(1, 64));
            endcase
            case ($urandom_range(0, 4))
                0:       limit = 10'd0;
                1:       limit = 10'd512;
                2:       limit = 10'd1023;
                default: limit = 10'($urandom_range(1, 40));
            endcase
            minus_one = $urandom_range(0, 1) ? '1 : {$urandom, $urandom};
            configure(2'($urandom_range(0, 3)), width, minus_one, limit);
            no_gaps <= (phase == 2);
            sent = 0;
            while (sent < 45)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                send_poly(len);
                sent += len;
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
